// ===== rtl/core/bapwm_pkg.sv =====
package bapwm_pkg;

	localparam int PeriodW = 16;
	localparam int StepW   = 10;
	localparam int LevelW  = 6;
	localparam int TicksW  = 8;
	localparam int CfgIdxW = 3;
	localparam int CfgW    = 16;

	localparam logic [CfgIdxW-1:0] REG_PERIOD = 3'd0;
	localparam logic [CfgIdxW-1:0] REG_STEP   = 3'd1;
	localparam logic [CfgIdxW-1:0] REG_LVLMAX = 3'd2;
	localparam logic [CfgIdxW-1:0] REG_WRAP   = 3'd3;
	localparam logic [CfgIdxW-1:0] REG_HOLD   = 3'd4;
	localparam logic [CfgIdxW-1:0] REG_REPEAT = 3'd5;

	localparam logic [PeriodW-1:0] PERIOD_RST = 16'd46636;
	localparam logic [StepW-1:0]   STEP_RST   = 10'd100;
	localparam logic [LevelW-1:0]  LVLMAX_RST = 6'd25;
	localparam logic [LevelW-1:0]  WRAP_RST   = 6'd5;
	localparam logic [TicksW-1:0]  HOLD_RST   = 8'd100;
	localparam logic [TicksW-1:0]  REPEAT_RST = 8'd10;

	typedef struct packed {
		logic [PeriodW-1:0] period_counts;
		logic [StepW-1:0]   step_counts;
		logic [LevelW-1:0]  level_max;
		logic [LevelW-1:0]  wrap_level;
		logic [TicksW-1:0]  hold_ticks;
		logic [TicksW-1:0]  repeat_ticks;
	} cfg_t;

	// per-item strobes into the PWM core: advance, plus adjustments from the button machines
	typedef struct packed {
		logic adv;
		logic up_adj;
		logic down_adj;
	} step_ctl_t;

endpackage

// ===== rtl/core/bapwm_key.sv =====
module bapwm_key
	import bapwm_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              pressed,
	input  logic [TicksW-1:0] hold_ticks,
	input  logic [TicksW-1:0] repeat_ticks,
	output logic              adjust
);

	localparam logic [1:0] ST_IDLE    = 2'd0;
	localparam logic [1:0] ST_CONFIRM = 2'd1;
	localparam logic [1:0] ST_HELD    = 2'd2;
	localparam logic [1:0] ST_REPEAT  = 2'd3;

	logic [1:0]        st_q, st_n;
	logic [TicksW-1:0] tm_q, tm_n;
	logic [TicksW:0]   tm_inc;
	logic              adj_c;

	assign tm_inc = {1'b0, tm_q} + {{TicksW{1'b0}}, 1'b1};

	always_comb begin
		st_n  = st_q;
		tm_n  = tm_q;
		adj_c = 1'b0;
		unique case (st_q)
			ST_IDLE: begin
				st_n = pressed ? ST_CONFIRM : ST_IDLE;
				tm_n = '0;
			end
			ST_CONFIRM: begin
				st_n = pressed ? ST_HELD : ST_IDLE;
				tm_n = '0;
			end
			ST_HELD: begin
				if (tm_inc > {1'b0, hold_ticks}) begin
					tm_n = '0;
					st_n = ST_REPEAT;
				end else if (!pressed) begin
					adj_c = 1'b1;
					tm_n  = '0;
					st_n  = ST_IDLE;
				end else begin
					tm_n = tm_inc[TicksW-1:0];
				end
			end
			default: begin
				// repeat: the interval can still fire on the release tick
				adj_c = tm_inc > {1'b0, repeat_ticks};
				st_n  = pressed ? ST_REPEAT : ST_IDLE;
				tm_n  = (!pressed || adj_c) ? '0 : tm_inc[TicksW-1:0];
			end
		endcase
	end

	assign adjust = en & adj_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			tm_q <= '0;
		end else if (en) begin
			st_q <= st_n;
			tm_q <= tm_n;
		end
	end

	a_timer_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_IDLE || st_q == ST_CONFIRM) |-> (tm_q == '0))
		else $error("button timer running outside held/repeat");

endmodule

// ===== rtl/core/bapwm_gen.sv =====
module bapwm_gen
	import bapwm_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  step_ctl_t         ctl,
	input  cfg_t              cfg,
	output logic              pwm_out,
	output logic [LevelW-1:0] level
);

	logic               phase_q;
	logic [PeriodW-1:0] count_q;
	logic [LevelW-1:0]  level_q, level_n;
	logic [PeriodW-1:0] high_len, len_raw, len;
	logic [PeriodW:0]   count_inc;
	logic               phase_end;

	always_comb begin
		level_n = level_q;
		if (ctl.up_adj) begin
			level_n = (level_q >= cfg.level_max) ? cfg.wrap_level
			                                     : level_q + LevelW'(1);
		end else if (ctl.down_adj) begin
			level_n = (level_q <= LevelW'(1)) ? LevelW'(1) : level_q - LevelW'(1);
		end
	end

	// 63 * 1023 fits the period width
	assign high_len = {{(PeriodW-LevelW){1'b0}}, level_n} *
	                  {{(PeriodW-StepW){1'b0}}, cfg.step_counts};

	always_comb begin
		if (phase_q)
			len_raw = high_len;
		else if (cfg.period_counts > high_len)
			len_raw = cfg.period_counts - high_len;
		else
			len_raw = PeriodW'(1);
		len = (len_raw == '0) ? PeriodW'(1) : len_raw;
	end

	assign count_inc = {1'b0, count_q} + {{PeriodW{1'b0}}, 1'b1};
	assign phase_end = count_inc >= {1'b0, len};

	assign pwm_out = phase_q;
	assign level   = level_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= 1'b1;
			count_q <= '0;
			level_q <= WRAP_RST;
		end else if (ctl.adv) begin
			level_q <= level_n;
			if (phase_end) begin
				count_q <= '0;
				phase_q <= ~phase_q;
			end else begin
				count_q <= count_inc[PeriodW-1:0];
			end
		end
	end

	a_level_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!(ctl.up_adj || ctl.down_adj) |=> $stable(level_q))
		else $error("level moved without a button adjustment");

endmodule

// ===== rtl/core/button_adjusted_pwm.sv =====
// Input beats are registered in the input stage, results in the register on m_tdata.
// Throughput: one beat per cycle unless m_tready stalls; the level/phase update
// is combinational: button machine, level mux, 6x10 multiply, phase length compare.
// Reset: arst_n clears the pipeline, returns registers to their defaults, the
// level to 5, both button machines to idle and the PWM to the start of a high phase.
module button_adjusted_pwm
	import bapwm_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [7:0]         s_tdata,   // [0] scan_tick, [1] up_key, [2] down_key
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [7:0]         m_tdata,   // [0] pwm_out, [6:1] duty_level
	input  logic               cfg_we,
	input  logic [CfgIdxW-1:0] cfg_index,
	input  logic [CfgW-1:0]    cfg_data
);

	cfg_t              cfg_q;
	logic              valid_s1;
	logic [2:0]        item_s1;
	logic              out_ready;
	logic              adv;
	logic              tick_en;
	logic              up_adj, down_adj;
	step_ctl_t         ctl;
	logic              pwm_c;
	logic [LevelW-1:0] level_c;
	logic              pwm_q;
	logic [LevelW-1:0] level_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.period_counts <= PERIOD_RST;
			cfg_q.step_counts   <= STEP_RST;
			cfg_q.level_max     <= LVLMAX_RST;
			cfg_q.wrap_level    <= WRAP_RST;
			cfg_q.hold_ticks    <= HOLD_RST;
			cfg_q.repeat_ticks  <= REPEAT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_PERIOD: cfg_q.period_counts <= cfg_data;
				REG_STEP:   cfg_q.step_counts   <= cfg_data[StepW-1:0];
				REG_LVLMAX: cfg_q.level_max     <= cfg_data[LevelW-1:0];
				REG_WRAP:   cfg_q.wrap_level    <= cfg_data[LevelW-1:0];
				REG_HOLD:   cfg_q.hold_ticks    <= cfg_data[TicksW-1:0];
				REG_REPEAT: cfg_q.repeat_ticks  <= cfg_data[TicksW-1:0];
				default: ;
			endcase
		end
	end

	// result register frees when empty or taken; input stage moves into it
	assign out_ready = !m_tvalid || m_tready;
	assign adv       = valid_s1 && out_ready;
	assign s_tready  = !valid_s1 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (s_tready)
			valid_s1 <= s_tvalid;
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid)
			item_s1 <= s_tdata[2:0];
	end

	assign tick_en = adv && item_s1[0];

	bapwm_key u_up_key (
		.clk          (clk),
		.arst_n       (arst_n),
		.en           (tick_en),
		.pressed      (!item_s1[1]),
		.hold_ticks   (cfg_q.hold_ticks),
		.repeat_ticks (cfg_q.repeat_ticks),
		.adjust       (up_adj)
	);

	bapwm_key u_down_key (
		.clk          (clk),
		.arst_n       (arst_n),
		.en           (tick_en),
		.pressed      (!item_s1[2]),
		.hold_ticks   (cfg_q.hold_ticks),
		.repeat_ticks (cfg_q.repeat_ticks),
		.adjust       (down_adj)
	);

	assign ctl.adv      = adv;
	assign ctl.up_adj   = up_adj;
	assign ctl.down_adj = down_adj;

	bapwm_gen u_gen (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (ctl),
		.cfg     (cfg_q),
		.pwm_out (pwm_c),
		.level   (level_c)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_tvalid <= 1'b0;
		else if (out_ready)
			m_tvalid <= valid_s1;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pwm_q   <= pwm_c;
			level_q <= level_c;
		end
	end

	assign m_tdata = {1'b0, level_q, pwm_q};

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !out_ready) |=> valid_s1)
		else $error("input stage dropped a beat while stalled");

	a_adv_result: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> m_tvalid)
		else $error("advanced beat did not reach the result register");

	a_ready_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (valid_s1 && m_tvalid && !m_tready))
		else $error("input stalled without a full pipeline");

endmodule

// ===== sim/tb.sv =====
module tb;
	import bapwm_pkg::*;

	localparam int StallLimit = 1000;

	typedef enum logic [1:0] {KEY_IDLE, KEY_CONFIRM, KEY_HELD, KEY_REPEAT} key_state_e;
	typedef enum logic [1:0] {RX_OPEN, RX_LIGHT, RX_HEAVY, RX_PULSE} rx_mode_e;

	typedef struct packed {
		logic       pwm;
		logic [5:0] duty;
	} pwm_sample_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               s_tvalid = 1'b0;
	logic               s_tready;
	logic [7:0]         s_tdata = '0;   // [0] scan_tick, [1] up_key, [2] down_key
	logic               m_tvalid;
	logic               m_tready = 1'b0;
	logic [7:0]         m_tdata;        // [0] pwm_out, [6:1] duty_level
	logic               cfg_we = 1'b0;
	logic [CfgIdxW-1:0] cfg_index = '0;
	logic [CfgW-1:0]    cfg_data = '0;

	button_adjusted_pwm DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// register copies and predicted block state
	logic [PeriodW-1:0] m_period = PERIOD_RST;
	logic [StepW-1:0]   m_step   = STEP_RST;
	logic [LevelW-1:0]  m_lvl_max = LVLMAX_RST;
	logic [LevelW-1:0]  m_wrap   = WRAP_RST;
	logic [TicksW-1:0]  m_hold   = HOLD_RST;
	logic [TicksW-1:0]  m_repeat = REPEAT_RST;

	logic        phase = 1'b1;
	logic [15:0] phase_cnt = '0;
	logic [5:0]  lvl = 6'd5;
	key_state_e  up_st = KEY_IDLE;
	key_state_e  dn_st = KEY_IDLE;
	logic [7:0]  up_tmr = '0;
	logic [7:0]  dn_tmr = '0;

	pwm_sample_t pending_samples[$];
	int          mismatches = 0;
	int          items_sent = 0;
	int          burst_left = 0;
	int          tick_gap = 1;
	int          idle_cycles = 0;
	rx_mode_e    rx_mode = RX_OPEN;
	int          rx_left = 0;

	function automatic logic scan_key(inout key_state_e st, inout logic [7:0] tmr,
			input logic pressed);
		logic [8:0] nxt;
		logic       adj;
		adj = 1'b0;
		nxt = {1'b0, tmr} + 9'd1;
		case (st)
		KEY_IDLE: begin
			st  = pressed ? KEY_CONFIRM : KEY_IDLE;
			tmr = '0;
		end
		KEY_CONFIRM: begin
			st  = pressed ? KEY_HELD : KEY_IDLE;
			tmr = '0;
		end
		KEY_HELD: begin
			if (nxt > {1'b0, m_hold}) begin
				tmr = '0;
				st  = KEY_REPEAT;
			end else if (!pressed) begin
				adj = 1'b1;
				tmr = '0;
				st  = KEY_IDLE;
			end else begin
				tmr = nxt[7:0];
			end
		end
		default: begin
			if (!pressed)
				st = KEY_IDLE;
			// repeat fires on the release tick too
			if (nxt > {1'b0, m_repeat}) begin
				nxt = '0;
				adj = 1'b1;
			end
			tmr = (st == KEY_IDLE) ? 8'd0 : nxt[7:0];
		end
		endcase
		return adj;
	endfunction

	function automatic void advance_count(input logic tick, input logic up_p, input logic dn_p);
		logic        up_adj;
		logic        dn_adj;
		int          high_len;
		int          len;
		pwm_sample_t smp;
		if (tick) begin
			up_adj = scan_key(up_st, up_tmr, up_p);
			dn_adj = scan_key(dn_st, dn_tmr, dn_p);
			if (up_adj)
				lvl = (lvl >= m_lvl_max) ? m_wrap : lvl + 6'd1;
			else if (dn_adj)
				lvl = (lvl <= 6'd1) ? 6'd1 : lvl - 6'd1;
		end
		high_len = int'(lvl) * int'(m_step);
		if (phase)
			len = high_len;
		else
			len = (int'(m_period) > high_len) ? int'(m_period) - high_len : 1;
		if (len < 1)
			len = 1;
		smp.pwm  = phase;
		smp.duty = lvl;
		if (int'(phase_cnt) + 1 >= len) begin
			phase_cnt = '0;
			phase = ~phase;
		end else begin
			phase_cnt = phase_cnt + 16'd1;
		end
		pending_samples.push_back(smp);
	endfunction

	task automatic send_item(input logic tick, input logic up_k, input logic dn_k);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
			if (gap != 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {5'b0, dn_k, up_k, tick};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		burst_left--;
		items_sent++;
		advance_count(tick, !up_k, !dn_k);
	endtask

	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (pending_samples.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic load_settings(input logic [15:0] period, input logic [9:0] step,
			input logic [5:0] lmax, input logic [5:0] wrap, input logic [7:0] hold,
			input logic [7:0] rpt);
		logic [CfgIdxW-1:0] idx [6];
		logic [CfgW-1:0]    val [6];
		idx = '{REG_PERIOD, REG_STEP, REG_LVLMAX, REG_WRAP, REG_HOLD, REG_REPEAT};
		val = '{period, {6'b0, step}, {10'b0, lmax}, {10'b0, wrap}, {8'b0, hold},
			{8'b0, rpt}};
		drain_results();
		for (int i = 0; i < 6; i++) begin
			cfg_we    <= 1'b1;
			cfg_index <= idx[i];
			cfg_data  <= val[i];
			@(posedge clk);
		end
		cfg_we    <= 1'b0;
		m_period  = period;
		m_step    = step;
		m_lvl_max = lmax;
		m_wrap    = wrap;
		m_hold    = hold;
		m_repeat  = rpt;
	endtask

	// hold each key for its number of scan ticks, then release both on one tick
	task automatic press_keys(input int up_ticks, input int dn_ticks);
		int span;
		span = (up_ticks > dn_ticks) ? up_ticks : dn_ticks;
		for (int k = 0; k < span; k++) begin
			repeat ($urandom_range(0, tick_gap))
				send_item(1'b0, 1'($urandom), 1'($urandom));
			send_item(1'b1, k >= up_ticks, k >= dn_ticks);
		end
		send_item(1'b1, 1'b1, 1'b1);
	endtask

	function automatic int press_len();
		case ($urandom_range(0, 3))
		0: return $urandom_range(1, 2);
		1: return $urandom_range(3, int'(m_hold) + 2);
		default: return $urandom_range(int'(m_hold) + 2,
			int'(m_hold) + 3 + 3 * (int'(m_repeat) + 1));
		endcase
	endfunction

	task automatic random_traffic(input int n);
		int stop;
		int len;
		stop = items_sent + n;
		while (items_sent < stop) begin
			case ($urandom_range(0, 6))
			0, 1: press_keys(press_len(), 0);
			2: press_keys(0, press_len());
			3: begin
				len = press_len();
				press_keys(len, len);
			end
			4: press_keys(press_len(), press_len());
			default: repeat ($urandom_range(1, 8))
				send_item(1'($urandom), 1'($urandom), 1'($urandom));
			endcase
		end
	endtask

	task automatic test_directed();
		send_item(1'b1, 1'b1, 1'b1);
		// keys on counts without a scan tick are ignored
		send_item(1'b0, 1'b0, 1'b0);
		send_item(1'b0, 1'b1, 1'b0);
		send_item(1'b0, 1'b0, 1'b1);
		// short up press, short down press
		send_item(1'b1, 1'b0, 1'b1);
		send_item(1'b1, 1'b0, 1'b1);
		send_item(1'b1, 1'b1, 1'b1);
		send_item(1'b1, 1'b1, 1'b0);
		send_item(1'b1, 1'b1, 1'b0);
		send_item(1'b1, 1'b1, 1'b1);
		// both released together: up wins
		send_item(1'b1, 1'b0, 1'b0);
		send_item(1'b1, 1'b0, 1'b0);
		send_item(1'b1, 1'b1, 1'b1);
		// confirm then release: no adjustment
		send_item(1'b1, 1'b0, 1'b1);
		send_item(1'b1, 1'b1, 1'b1);
		send_item(1'b0, 1'b1, 1'b1);
	endtask

	task automatic test_repeat_wrap();
		load_settings(16'd40, 10'd1, 6'd63, 6'd62, 8'd2, 8'd1);
		tick_gap = 0;
		press_keys(140, 0);
		press_keys(0, 140);
		tick_gap = 1;
		press_keys(20, 20);
		press_keys(6, 25);
	endtask

	task automatic test_timer_limit();
		load_settings(16'd65535, 10'd1000, 6'd63, 6'd63, 8'd255, 8'd255);
		tick_gap = 0;
		press_keys(262, 262);
		press_keys(3, 3);
	endtask

	task automatic test_minimum();
		load_settings(16'd1, 10'd1, 6'd1, 6'd1, 8'd1, 8'd1);
		tick_gap = 1;
		random_traffic(150);
	endtask

	task automatic test_low_floor();
		// high phase always longer than the period: low phase floors at one count
		load_settings(16'd5, 10'd7, 6'd20, 6'd10, 8'd3, 8'd2);
		tick_gap = 1;
		random_traffic(150);
	endtask

	task automatic test_random_settings();
		for (int r = 0; r < 3; r++) begin
			load_settings(16'($urandom_range(1, 120)), 10'($urandom_range(1, 6)),
				6'($urandom_range(1, 63)), 6'($urandom_range(1, 63)),
				8'($urandom_range(1, 6)), 8'($urandom_range(1, 4)));
			tick_gap = $urandom_range(0, 2);
			random_traffic(120);
		end
	endtask

	always @(posedge clk) begin
		if (rx_left == 0) begin
			rx_mode = rx_mode_e'($urandom_range(0, 3));
			rx_left = $urandom_range(8, 64);
		end
		rx_left--;
		case (rx_mode)
		RX_OPEN: m_tready <= 1'b1;
		RX_LIGHT: m_tready <= ($urandom_range(0, 3) != 0);
		RX_HEAVY: m_tready <= ($urandom_range(0, 3) == 0);
		default: m_tready <= (rx_left % 4 != 0);
		endcase
	end

	always @(posedge clk) begin
		pwm_sample_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_samples.size() == 0) begin
				$display("%0t unexpected result beat: expected none, actual %h", $time, m_tdata);
				mismatches++;
			end else begin
				want = pending_samples.pop_front();
				if (m_tdata[0] !== want.pwm) begin
					$display("%0t pwm_out: expected %0d, actual %0d", $time, want.pwm, m_tdata[0]);
					mismatches++;
				end
				if (m_tdata[6:1] !== want.duty) begin
					$display("%0t duty_level: expected %0d, actual %0d", $time, want.duty,
						m_tdata[6:1]);
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= StallLimit) begin
			$display("%0t no beat moved for %0d cycles", $time, StallLimit);
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_repeat_wrap();
		test_timer_limit();
		test_minimum();
		test_low_floor();
		test_random_settings();
		drain_results();
		if (mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
